// ===== src/wfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// wfpd_pkg
// Shared types and constants of the wall-following PD steering block.
// ----------------------------------------------------------------------------
package wfpd_pkg;

	localparam int unsigned GAIN_INV_Q15 = 19898;
	localparam int unsigned SIN_PI9_Q15  = 11207;
	localparam int unsigned SPEED_FAST   = 10000;
	localparam int unsigned SPEED_CHECK  = 4000;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [2:0] REG_DIFF_GAIN  = 3'd1;
	localparam logic [2:0] REG_TARGET     = 3'd2;
	localparam logic [2:0] REG_LOOK_AHEAD = 3'd3;
	localparam logic [2:0] REG_COS_GAP    = 3'd4;
	localparam logic [2:0] REG_SIN_GAP    = 3'd5;
	localparam logic [2:0] REG_MISMATCH   = 3'd6;

	typedef struct packed {
		logic [15:0] prop_gain;
		logic [15:0] diff_gain_rate;
		logic [15:0] target_distance;
		logic [15:0] look_ahead;
		logic [14:0] cos_beam_gap;
		logic [14:0] sin_beam_gap;
		logic [15:0] mismatch_limit;
	} cfg_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_PREP,
		OP_ROTATE,
		OP_SCALE,
		OP_DIST,
		OP_ERROR,
		OP_GAIN
	} op_t;

	// FINISH shares no arm with the others, so it is a separate flag.
	typedef struct packed {
		op_t  op;
		logic finish;
	} dp_cmd_t;

endpackage

// ===== src/wfpd_regs.sv =====
// ----------------------------------------------------------------------------
// wfpd_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module wfpd_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output wfpd_pkg::cfg_t     cfg
);

	wfpd_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     idx;

	assign idx   = paddr[4:2];
	assign wr_en = psel & penable & pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain       <= 16'd2048;
			cfg_q.diff_gain_rate  <= 16'd819;
			cfg_q.target_distance <= 16'd1000;
			cfg_q.look_ahead      <= 16'd1000;
			cfg_q.cos_beam_gap    <= 15'd21063;
			cfg_q.sin_beam_gap    <= 15'd25102;
			cfg_q.mismatch_limit  <= 16'd28;
		end else if (wr_en) begin
			unique case (idx)
				wfpd_pkg::REG_PROP_GAIN:  cfg_q.prop_gain       <= pwdata[15:0];
				wfpd_pkg::REG_DIFF_GAIN:  cfg_q.diff_gain_rate  <= pwdata[15:0];
				wfpd_pkg::REG_TARGET:     cfg_q.target_distance <= pwdata[15:0];
				wfpd_pkg::REG_LOOK_AHEAD: cfg_q.look_ahead      <= pwdata[15:0];
				wfpd_pkg::REG_COS_GAP:    cfg_q.cos_beam_gap    <= pwdata[14:0];
				wfpd_pkg::REG_SIN_GAP:    cfg_q.sin_beam_gap    <= pwdata[14:0];
				wfpd_pkg::REG_MISMATCH:   cfg_q.mismatch_limit  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			wfpd_pkg::REG_PROP_GAIN:  prdata = {16'd0, cfg_q.prop_gain};
			wfpd_pkg::REG_DIFF_GAIN:  prdata = {16'd0, cfg_q.diff_gain_rate};
			wfpd_pkg::REG_TARGET:     prdata = {16'd0, cfg_q.target_distance};
			wfpd_pkg::REG_LOOK_AHEAD: prdata = {16'd0, cfg_q.look_ahead};
			wfpd_pkg::REG_COS_GAP:    prdata = {17'd0, cfg_q.cos_beam_gap};
			wfpd_pkg::REG_SIN_GAP:    prdata = {17'd0, cfg_q.sin_beam_gap};
			wfpd_pkg::REG_MISMATCH:   prdata = {16'd0, cfg_q.mismatch_limit};
			default:                  prdata = 32'd0;
		endcase
	end

endmodule

// ===== src/wfpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// wfpd_ctrl
// Sequencer: steps the datapath through one item and owns both handshakes.
// ----------------------------------------------------------------------------
module wfpd_ctrl #(
	parameter int CORDIC_STEPS = 16,
	parameter int IW = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output wfpd_pkg::dp_cmd_t   cmd,
	output logic [IW-1:0]       step
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_PREP, ST_ROT, ST_SCALE, ST_DIST, ST_ERR, ST_GAIN, ST_FIN
	} state_t;

	state_t        state_q;
	logic [IW-1:0] cnt_q;
	logic          valid_q;
	logic          out_free;

	assign out_free = !valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = valid_q;
	assign step     = cnt_q;

	always_comb begin
		cmd.finish = 1'b0;
		unique case (state_q)
			ST_IDLE:  cmd.op = s_tvalid ? wfpd_pkg::OP_LOAD : wfpd_pkg::OP_NONE;
			ST_PREP:  cmd.op = wfpd_pkg::OP_PREP;
			ST_ROT:   cmd.op = wfpd_pkg::OP_ROTATE;
			ST_SCALE: cmd.op = wfpd_pkg::OP_SCALE;
			ST_DIST:  cmd.op = wfpd_pkg::OP_DIST;
			ST_ERR:   cmd.op = wfpd_pkg::OP_ERROR;
			ST_GAIN:  cmd.op = wfpd_pkg::OP_GAIN;
			ST_FIN: begin
				cmd.op     = wfpd_pkg::OP_NONE;
				cmd.finish = out_free;
			end
			default:  cmd.op = wfpd_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			// A new result may replace one that leaves at the same edge.
			if (state_q == ST_FIN && out_free) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (s_tvalid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP:  state_q <= ST_ROT;
				ST_ROT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IW'(CORDIC_STEPS - 1)) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_DIST;
				ST_DIST:  state_q <= ST_ERR;
				ST_ERR:   state_q <= ST_GAIN;
				ST_GAIN:  state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/wfpd_dp.sv =====
// ----------------------------------------------------------------------------
// wfpd_dp
// Datapath: CORDIC wall-angle vectoring, beam c check and PD law.
// ----------------------------------------------------------------------------
module wfpd_dp #(
	parameter int RANGE_BITS = 16,
	parameter int IW = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wfpd_pkg::cfg_t     cfg,
	input  wfpd_pkg::dp_cmd_t  cmd,
	input  logic [IW-1:0]      step,
	input  logic [15:0]        range_a,
	input  logic [15:0]        range_b,
	input  logic [15:0]        range_c,
	output logic [15:0]        steer_angle,
	output logic [13:0]        drive_speed,
	output logic [17:0]        wall_distance,
	output logic               beam_mismatch
);

	localparam logic [16:0] RMAX = (RANGE_BITS >= 16) ? 17'h0FFFF
		: 17'((64'd1 << RANGE_BITS) - 64'd1);

	logic [15:0]        ra_q, rb_q, rc_q;
	logic signed [35:0] num_q, den_q, px_q, py_q;
	logic               den_zero_q, num_pos_q, num_neg_q;
	logic [31:0]        rab_q, cden_q;
	logic signed [51:0] prod_q;
	logic [46:0]        mm1_q;
	logic [47:0]        mm2_q, lim_q;
	logic signed [22:0] dist_q;
	logic               mism_q;
	logic signed [17:0] err_q, last_q;
	logic signed [34:0] p1_q;
	logic signed [35:0] p2_q;
	logic [15:0]        steer_q;
	logic [13:0]        speed_q;
	logic [17:0]        wdist_q;
	logic               bm_q;

	// Combinational helpers.
	logic [30:0]        racos, rasin;
	logic signed [35:0] num_c;
	logic signed [35:0] num_sh, den_sh, px_sh, py_sh;
	logic signed [22:0] dist_c;
	logic signed [48:0] diff_c;
	logic [47:0]        adiff_c;
	logic signed [23:0] err_c;
	logic signed [18:0] derr_c;
	logic signed [36:0] sum_c;
	logic signed [24:0] ang_c;
	logic signed [25:0] nang_c;
	logic [24:0]        mag_c;

	function automatic logic [15:0] sat_range(input logic [15:0] v);
		return ({1'b0, v} > RMAX) ? RMAX[15:0] : v;
	endfunction

	assign racos = ra_q * cfg.cos_beam_gap;
	assign rasin = ra_q * cfg.sin_beam_gap;
	assign num_c = $signed({5'd0, racos}) - $signed({5'd0, rb_q, 15'd0});

	assign num_sh = num_q >>> step;
	assign den_sh = den_q >>> step;
	assign px_sh  = px_q >>> step;
	assign py_sh  = py_q >>> step;

	always_comb begin
		if (den_zero_q) begin
			if (num_pos_q)      dist_c = $signed({7'd0, cfg.look_ahead});
			else if (num_neg_q) dist_c = -$signed({7'd0, cfg.look_ahead});
			else                dist_c = $signed({7'd0, rb_q});
		end else begin
			dist_c = 23'((prod_q + 52'sd268435456) >>> 29);
		end
	end

	assign diff_c  = $signed({2'd0, mm1_q}) - $signed({1'b0, mm2_q});
	assign adiff_c = diff_c[48] ? 48'(-diff_c) : diff_c[47:0];
	assign err_c   = $signed({8'd0, cfg.target_distance}) - 24'(dist_q);
	assign derr_c  = 19'(err_q) - 19'(last_q);
	assign sum_c   = 37'(p1_q) + 37'(p2_q) + 37'sd2048;
	assign ang_c   = 25'(sum_c >>> 12);
	assign nang_c  = -26'(ang_c);
	assign mag_c   = ang_c[24] ? 25'(nang_c) : ang_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (cmd.op == wfpd_pkg::OP_GAIN) begin
			last_q <= err_q;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			wfpd_pkg::OP_LOAD: begin
				ra_q <= sat_range(range_a);
				rb_q <= sat_range(range_b);
				rc_q <= sat_range(range_c);
			end
			wfpd_pkg::OP_PREP: begin
				num_q      <= num_c;
				den_q      <= $signed({5'd0, rasin});
				px_q       <= $signed({6'd0, rb_q, 14'd0});
				py_q       <= $signed({6'd0, cfg.look_ahead, 14'd0});
				den_zero_q <= (rasin == 31'd0);
				num_pos_q  <= !num_c[35] && (num_c != 36'sd0);
				num_neg_q  <= num_c[35];
				rab_q      <= ra_q * rb_q;
				cden_q     <= 32'(ra_q) * 32'(wfpd_pkg::SIN_PI9_Q15) + {2'd0, rb_q, 14'd0};
			end
			wfpd_pkg::OP_ROTATE: begin
				// Vectoring: drive num toward zero, carry (px, py) along.
				if (!num_q[35]) begin
					den_q <= den_q + num_sh;
					num_q <= num_q - den_sh;
					px_q  <= px_q + py_sh;
					py_q  <= py_q - px_sh;
				end else begin
					den_q <= den_q - num_sh;
					num_q <= num_q + den_sh;
					px_q  <= px_q - py_sh;
					py_q  <= py_q + px_sh;
				end
			end
			wfpd_pkg::OP_SCALE: begin
				prod_q <= px_q * $signed(16'(wfpd_pkg::GAIN_INV_Q15));
				mm1_q  <= rab_q * cfg.sin_beam_gap;
				mm2_q  <= rc_q * cden_q;
				lim_q  <= cfg.mismatch_limit * cden_q;
			end
			wfpd_pkg::OP_DIST: begin
				dist_q <= dist_c;
				mism_q <= (cden_q == 32'd0) || (adiff_c >= lim_q);
			end
			wfpd_pkg::OP_ERROR: begin
				if (err_c > 24'sd131071)       err_q <= 18'sd131071;
				else if (err_c < -24'sd131072) err_q <= -18'sd131072;
				else                           err_q <= 18'(err_c);
			end
			wfpd_pkg::OP_GAIN: begin
				p1_q <= $signed({1'b0, cfg.prop_gain}) * err_q;
				p2_q <= $signed({1'b0, cfg.diff_gain_rate}) * derr_c;
			end
			default: ;
		endcase

		if (cmd.finish) begin
			if (nang_c > 26'sd32767)       steer_q <= 16'h7FFF;
			else if (nang_c < -26'sd32768) steer_q <= 16'h8000;
			else                           steer_q <= nang_c[15:0];

			if (mag_c > 25'd174)      speed_q <= 14'd800;
			else if (mag_c > 25'd122) speed_q <= 14'd1300;
			else if (mag_c > 25'd87)  speed_q <= 14'd1500;
			else if (mag_c > 25'd34)  speed_q <= 14'd2000;
			else if (mism_q)          speed_q <= 14'(wfpd_pkg::SPEED_CHECK);
			else                      speed_q <= 14'(wfpd_pkg::SPEED_FAST);

			if (dist_q > 23'sd131071)       wdist_q <= 18'h1FFFF;
			else if (dist_q < -23'sd131072) wdist_q <= 18'h20000;
			else                            wdist_q <= dist_q[17:0];

			bm_q <= mism_q;
		end
	end

	assign steer_angle   = steer_q;
	assign drive_speed   = speed_q;
	assign wall_distance = wdist_q;
	assign beam_mismatch = bm_q;

endmodule

// ===== src/wall_follow_pd_steering_top.sv =====
// ----------------------------------------------------------------------------
// wall_follow_pd_steering_top
// Wall-following PD steering controller with APB configuration.
// ----------------------------------------------------------------------------
// Each item of three lidar ranges yields one result: steering angle, speed,
// projected wall distance and the beam c mismatch flag. The block works on one
// item at a time: after an item is accepted it steps through PREP, the CORDIC
// vectoring unit that does one micro-rotation per cycle, SCALE, DIST, ERR, GAIN
// and FIN, which registers the result, and then returns to idle, where the
// next item can be accepted. A finished result sits in the output register and
// the next item may be accepted while it waits; a further result then stalls
// until it leaves.
module wall_follow_pd_steering_top #(
	parameter int CORDIC_STEPS = 16,
	parameter int RANGE_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // range_a, range_b, range_c
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // steer_angle, drive_speed, wall_distance, beam_mismatch
);

	localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	wfpd_pkg::cfg_t    cfg;
	wfpd_pkg::dp_cmd_t cmd;
	logic [IW-1:0]     step;
	logic [15:0]       steer_angle;
	logic [13:0]       drive_speed;
	logic [17:0]       wall_distance;
	logic              beam_mismatch;

	assign pready = 1'b1;

	wfpd_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
	);

	wfpd_ctrl #(.CORDIC_STEPS(CORDIC_STEPS), .IW(IW)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .cmd(cmd), .step(step)
	);

	wfpd_dp #(.RANGE_BITS(RANGE_BITS), .IW(IW)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .cmd(cmd), .step(step),
		.range_a(s_tdata[15:0]), .range_b(s_tdata[31:16]), .range_c(s_tdata[47:32]),
		.steer_angle(steer_angle), .drive_speed(drive_speed),
		.wall_distance(wall_distance), .beam_mismatch(beam_mismatch)
	);

	assign m_tdata = {7'd0, beam_mismatch, wall_distance, drive_speed, steer_angle};

endmodule

// ===== src/wfpd_checker.sv =====
// ----------------------------------------------------------------------------
// wfpd_checker
// Port-level checks of the steering block, bound to the top level.
// ----------------------------------------------------------------------------
module wfpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        pready
);

	// A held result must not be dropped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// The block is busy right after taking an item.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while busy");

	// No result can appear on the cycle after acceptance.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result too early");

	// Speed never exceeds the fast base speed.
	a_speed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[29:16] <= 14'd10000)
		else $error("speed out of range");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind wall_follow_pd_steering_top wfpd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);

// ===== verif/wall_follow_pd_steering_checker.sv =====
// ----------------------------------------------------------------------------
// wall_follow_pd_steering_checker
// Watches the range and steering streams and the register port, predicts each
// steering result from the accepted ranges and compares it field by field.
// ----------------------------------------------------------------------------
module wall_follow_pd_steering_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,  // range_a, range_b, range_c
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,  // steer_angle, drive_speed, wall_distance, beam_mismatch
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic        beam_mismatch;
		logic [17:0] wall_distance;
		logic [13:0] drive_speed;
		logic [15:0] steer_angle;
	} steer_result_t;

	wfpd_pkg::cfg_t regs;
	longint         held_err;
	steer_result_t  expected_q[$];

	assign pending = expected_q.size();

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint project_distance(longint ra, longint rb);
		longint num, den, px, py, nx, ny, qx, qy;
		num = ra * longint'(regs.cos_beam_gap) - rb * 32768;
		den = ra * longint'(regs.sin_beam_gap);
		px  = rb * 16384;
		py  = longint'(regs.look_ahead) * 16384;
		if (den == 0) begin
			if (num > 0) return longint'(regs.look_ahead);
			if (num < 0) return -longint'(regs.look_ahead);
			return rb;
		end
		for (int i = 0; i < 16; i++) begin
			if (num >= 0) begin
				nx = den + fshift(num, i); ny = num - fshift(den, i);
				qx = px + fshift(py, i);   qy = py - fshift(px, i);
			end else begin
				nx = den - fshift(num, i); ny = num + fshift(den, i);
				qx = px - fshift(py, i);   qy = py + fshift(px, i);
			end
			den = nx; num = ny; px = qx; py = qy;
		end
		return fshift(px * longint'(wfpd_pkg::GAIN_INV_Q15) + (longint'(1) << 28), 29);
	endfunction

	function automatic steer_result_t predict_steering(logic [47:0] ranges);
		longint ra, rb, rc, wdist, err, ang, mag, cden, diff, speed;
		logic   mism;
		steer_result_t r;
		ra = ranges[15:0];
		rb = ranges[31:16];
		rc = ranges[47:32];
		wdist = project_distance(ra, rb);
		cden = ra * longint'(wfpd_pkg::SIN_PI9_Q15) + rb * 16384;
		if (cden == 0) mism = 1'b1;
		else begin
			diff = ra * rb * longint'(regs.sin_beam_gap) - rc * cden;
			if (diff < 0) diff = -diff;
			mism = diff >= longint'(regs.mismatch_limit) * cden;
		end
		err = clamp(longint'(regs.target_distance) - wdist, -131072, 131071);
		ang = fshift(longint'(regs.prop_gain) * err
			+ longint'(regs.diff_gain_rate) * (err - held_err) + 2048, 12);
		held_err = err;
		mag = ang < 0 ? -ang : ang;
		if (mag > 174) speed = 800;
		else if (mag > 122) speed = 1300;
		else if (mag > 87) speed = 1500;
		else if (mag > 34) speed = 2000;
		else speed = mism ? longint'(wfpd_pkg::SPEED_CHECK) : longint'(wfpd_pkg::SPEED_FAST);
		r.steer_angle   = 16'(clamp(-ang, -32768, 32767));
		r.drive_speed   = 14'(speed);
		r.wall_distance = 18'(clamp(wdist, -131072, 131071));
		r.beam_mismatch = mism;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		steer_result_t got, want;
		if (!arst_n) begin
			regs.prop_gain       <= 16'd2048;
			regs.diff_gain_rate  <= 16'd819;
			regs.target_distance <= 16'd1000;
			regs.look_ahead      <= 16'd1000;
			regs.cos_beam_gap    <= 15'd21063;
			regs.sin_beam_gap    <= 15'd25102;
			regs.mismatch_limit  <= 16'd28;
			held_err = 0;
			fail_count <= 0;
			expected_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					wfpd_pkg::REG_PROP_GAIN:  regs.prop_gain       <= pwdata[15:0];
					wfpd_pkg::REG_DIFF_GAIN:  regs.diff_gain_rate  <= pwdata[15:0];
					wfpd_pkg::REG_TARGET:     regs.target_distance <= pwdata[15:0];
					wfpd_pkg::REG_LOOK_AHEAD: regs.look_ahead      <= pwdata[15:0];
					wfpd_pkg::REG_COS_GAP:    regs.cos_beam_gap    <= pwdata[14:0];
					wfpd_pkg::REG_SIN_GAP:    regs.sin_beam_gap    <= pwdata[14:0];
					wfpd_pkg::REG_MISMATCH:   regs.mismatch_limit  <= pwdata[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(predict_steering(s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata[48:0];
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("steering result with none expected: %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (got !== want || m_tdata[55:49] !== 7'd0) begin
						if (fail_count < 10)
							$display("mismatch: steer %0d/%0d speed %0d/%0d dist %0d/%0d flag %0d/%0d",
								$signed(want.steer_angle), $signed(got.steer_angle),
								want.drive_speed, got.drive_speed,
								$signed(want.wall_distance), $signed(got.wall_distance),
								want.beam_mismatch, got.beam_mismatch);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ===== verif/tb_wall_follow_pd_steering_top.sv =====
// ----------------------------------------------------------------------------
// tb_wall_follow_pd_steering_top
// Drives range items and register writes into the steering block under varying
// stream pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_wall_follow_pd_steering_top;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;  // range_a, range_b, range_c
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;       // steer_angle, drive_speed, wall_distance, beam_mismatch
	int          fail_count, pending;
	int          send_idle_pct, recv_idle_pct;
	bit          hold_off;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	wall_follow_pd_steering_top u_top (.*);

	wall_follow_pd_steering_checker u_chk (.*);

	// Receiver: random stalls, or a long hold-off when asked.
	always @(posedge clk)
		m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// The block is busy after taking an item, so dropping tvalid afterwards costs nothing.
	task automatic send_ranges(logic [15:0] ra, logic [15:0] rb, logic [15:0] rc);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {rc, rb, ra};
		do @(posedge clk); while (!s_tready);
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Mostly plausible wall geometry, with some fully random ranges.
	task automatic send_random();
		logic [15:0] ra, rb, rc;
		case ($urandom_range(9))
			0, 1: begin ra = $urandom; rb = $urandom; rc = $urandom; end
			2: begin ra = $urandom_range(3); rb = $urandom_range(3); rc = $urandom_range(3); end
			default: begin
				rb = $urandom_range(200, 3000);
				ra = rb + $urandom_range(0, 800);
				rc = $urandom_range(0, 1) ? (rb + ra) / 2 : $urandom_range(0, 4000);
			end
		endcase
		send_ranges(ra, rb, rc);
	endtask

	task automatic random_config();
		write_reg(wfpd_pkg::REG_PROP_GAIN,
			$urandom_range(0, 1) ? $urandom_range(0, 8192) : $urandom);
		write_reg(wfpd_pkg::REG_DIFF_GAIN,
			$urandom_range(0, 1) ? $urandom_range(0, 2048) : $urandom);
		write_reg(wfpd_pkg::REG_TARGET,
			$urandom_range(0, 1) ? $urandom_range(200, 3000) : $urandom);
		write_reg(wfpd_pkg::REG_LOOK_AHEAD, $urandom);
		write_reg(wfpd_pkg::REG_COS_GAP, $urandom);
		write_reg(wfpd_pkg::REG_SIN_GAP, $urandom);
		write_reg(wfpd_pkg::REG_MISMATCH,
			$urandom_range(0, 1) ? $urandom_range(0, 200) : $urandom);
	endtask

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		send_idle_pct = 21;
		recv_idle_pct = 71;
		hold_off = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, zero denominators, defaults.
		send_ranges(16'd0, 16'd0, 16'd0);
		send_ranges(16'd0, 16'd1000, 16'd0);
		send_ranges(16'd0, 16'hFFFF, 16'hFFFF);
		send_ranges(16'hFFFF, 16'd0, 16'd0);
		send_ranges(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_ranges(16'd1414, 16'd1000, 16'd1200);
		send_ranges(16'd1000, 16'd1000, 16'd500);
		send_ranges(16'd1, 16'hFFFF, 16'h5555);
		send_ranges(16'hAAAA, 16'h5555, 16'hAAAA);
		drain();
		// Extreme register values: zero denominator via zero sine, maximal gains.
		write_reg(wfpd_pkg::REG_SIN_GAP, 32'd0);
		write_reg(wfpd_pkg::REG_COS_GAP, 32'h7FFF);
		write_reg(wfpd_pkg::REG_PROP_GAIN, 32'hFFFF);
		write_reg(wfpd_pkg::REG_DIFF_GAIN, 32'hFFFF);
		write_reg(wfpd_pkg::REG_TARGET, 32'hFFFF);
		write_reg(wfpd_pkg::REG_LOOK_AHEAD, 32'hFFFF);
		write_reg(wfpd_pkg::REG_MISMATCH, 32'hFFFF);
		send_ranges(16'd500, 16'd0, 16'd10);
		send_ranges(16'd0, 16'd500, 16'd10);
		send_ranges(16'd0, 16'd0, 16'd0);
		send_ranges(16'hFFFF, 16'hFFFF, 16'd0);
		drain();
		write_reg(wfpd_pkg::REG_PROP_GAIN, 32'd0);
		write_reg(wfpd_pkg::REG_DIFF_GAIN, 32'd0);
		write_reg(wfpd_pkg::REG_TARGET, 32'd0);
		write_reg(wfpd_pkg::REG_LOOK_AHEAD, 32'd0);
		write_reg(wfpd_pkg::REG_COS_GAP, 32'd0);
		write_reg(wfpd_pkg::REG_SIN_GAP, 32'h7FFF);
		write_reg(wfpd_pkg::REG_MISMATCH, 32'd0);
		send_ranges(16'd1200, 16'd800, 16'd900);
		send_ranges(16'hFFFF, 16'd1, 16'hFFFF);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 2) begin
				send_idle_pct = 71; recv_idle_pct = 21;
			end else if (phase == 4) begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end
			if (phase == 5) begin
				write_reg(wfpd_pkg::REG_PROP_GAIN, 32'd2048);
				write_reg(wfpd_pkg::REG_DIFF_GAIN, 32'd819);
				write_reg(wfpd_pkg::REG_TARGET, 32'd1000);
				write_reg(wfpd_pkg::REG_LOOK_AHEAD, 32'd1000);
				write_reg(wfpd_pkg::REG_COS_GAP, 32'd21063);
				write_reg(wfpd_pkg::REG_SIN_GAP, 32'd25102);
				write_reg(wfpd_pkg::REG_MISMATCH, 32'd28);
			end else
				random_config();
			for (int n = 0; n < 180; n++) begin
				if (n == 60 && phase == 3) begin
					// Long receiver hold-off while items keep coming.
					hold_off <= 1'b1;
					fork
						begin repeat (300) @(posedge clk); hold_off <= 1'b0; end
					join_none
				end
				if (n == 120)
					while (pending != 0) @(posedge clk);
				send_random();
			end
			drain();
		end

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/wfpd_pkg.sv
src/wfpd_regs.sv
src/wfpd_ctrl.sv
src/wfpd_dp.sv
src/wall_follow_pd_steering_top.sv
src/wfpd_checker.sv
verif/wall_follow_pd_steering_checker.sv
verif/tb_wall_follow_pd_steering_top.sv
